>>> rtl/cpm_pkg.sv
// Package for the cab poll master: types, key codes, header codes and reset values.
// Used by cpm_cab_mem, cpm_update and cab_poll_master; depends on nothing.
package cpm_pkg;

    // Default number of cabs on the bus.
    localparam int NUM_CABS_DEF = 64;

    // Item kinds carried on cmd.
    localparam logic [1:0] CMD_POLL      = 2'd0;
    localparam logic [1:0] CMD_SET_SPEED = 2'd1;
    localparam logic [1:0] CMD_QUESTION  = 2'd2;
    localparam logic [1:0] CMD_MARK      = 2'd3;

    // Command codes reported after a full reply.
    localparam logic [1:0] CC_NONE     = 2'd0;
    localparam logic [1:0] CC_SELECT   = 2'd1;
    localparam logic [1:0] CC_RESPONSE = 2'd2;
    localparam logic [1:0] CC_SPEED    = 2'd3;

    // Key bytes from the cab.
    localparam logic [7:0] KEY_REPEAT    = 8'h7E;
    localparam logic [7:0] KEY_NONE      = 8'h7D;
    localparam logic [7:0] KEY_ENTER     = 8'h40;
    localparam logic [7:0] KEY_SELECT    = 8'h48;
    localparam logic [7:0] KEY_SPEED_UP  = 8'h4A;
    localparam logic [7:0] KEY_SPEED_DN  = 8'h4B;
    localparam logic [7:0] KEY_ANSWER_0  = 8'h50;
    localparam logic [7:0] KEY_ANSWER_1  = 8'h51;

    // Bytes sent on the bus.
    localparam logic [7:0] PING_BASE = 8'h80;
    localparam logic [7:0] HDR_TL    = 8'hC0;
    localparam logic [7:0] HDR_TR    = 8'hC1;
    localparam logic [7:0] HDR_BL    = 8'hC2;
    localparam logic [7:0] HDR_BR    = 8'hC3;

    // Screen masks: bit3 TL, bit2 BL, bit1 TR, bit0 BR.
    localparam logic [3:0] SCR_ALL    = 4'hF;
    localparam logic [3:0] SCR_BOTTOM = 4'h5;
    localparam logic [3:0] SCR_BL     = 4'h4;

    // Speed after reset: forward, step zero.
    localparam logic [7:0] SPEED_RESET = 8'h80;

    // Per-cab entry held in the state memory.
    typedef struct packed {
        logic [7:0]  speed;
        logic [3:0]  dirty;
        logic        question;
        logic        selecting;
        logic [31:0] last_seen;
    } cab_entry_t;

    localparam cab_entry_t ENTRY_RESET = '{
        speed:     SPEED_RESET,
        dirty:     SCR_ALL,
        question:  1'b0,
        selecting: 1'b0,
        last_seen: 32'd0
    };

    // Registered item held while its entry is read.
    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] reply_count;
        logic [7:0] key_code;
        logic [7:0] speed_value;
        logic [3:0] dirty_mask;
        logic       in_range;
    } item_t;

    // Result fields produced by the update logic.
    typedef struct packed {
        logic       present;
        logic [1:0] code;
        logic [7:0] value;
        logic       sent;
        logic [7:0] header;
    } result_t;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

>>> rtl/cab_poll_master.sv
// Cab poll master: one item per start beat, one result beat per item.
// The result strobe (done) is registered from the execution state. A new item is
// not taken while one is in execution, as its per-cab entry is read from the
// registered-read state memory and then written back; busy is high for one cycle.
// Reset clears the poll address, round count and the memory's valid bits at once;
// the results cannot be stalled by the receiver. Depends on cpm_pkg, cpm_cab_mem, cpm_update.
module cab_poll_master #(
    parameter int NUM_CABS = cpm_pkg::NUM_CABS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] cmd,
    input  logic [1:0] reply_count,
    input  logic [7:0] key_code,
    input  logic [5:0] cab_index,
    input  logic [7:0] speed_value,
    input  logic [3:0] dirty_mask,
    output logic       done,
    output logic [7:0] ping_byte,
    output logic       cab_present,
    output logic [1:0] command_code,
    output logic [7:0] command_value,
    output logic       screen_sent,
    output logic [7:0] screen_header
);

    localparam int ADDR_W = $clog2(NUM_CABS);

    cpm_pkg::state_t     state_reg, state_next;
    logic                accept;
    logic                exec;
    logic [ADDR_W-1:0]   poll_addr_reg;
    logic [31:0]         round_reg;
    logic [ADDR_W:0]     addr_cand;
    logic [ADDR_W-1:0]   addr_poll_next;
    logic                addr_wrap;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   addr_reg;
    logic [7:0]          ping_reg;
    cpm_pkg::item_t      item_reg;
    cpm_pkg::cab_entry_t entry_rd;
    cpm_pkg::cab_entry_t entry_wr;
    logic                wr_en;
    cpm_pkg::result_t    result;
    cpm_pkg::result_t    result_reg;
    logic                done_reg;

    // Next state: an accepted item moves to execution, and execution returns to idle.
    always_comb
    begin
        case (state_reg)
            cpm_pkg::ST_IDLE: state_next = start ? cpm_pkg::ST_EXEC : cpm_pkg::ST_IDLE;
            cpm_pkg::ST_EXEC: state_next = cpm_pkg::ST_IDLE;
            default:          state_next = cpm_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        case (state_reg)
            cpm_pkg::ST_EXEC: exec = 1'b1;
            default:          exec = 1'b0;
        endcase
    end

    assign busy   = exec;
    assign accept = start && !busy;

    // Next poll address: 0, then 3 upwards, wrapping at the last cab.
    always_comb
    begin
        if (poll_addr_reg == '0)
        begin
            addr_cand = (ADDR_W+1)'(3);
        end
        else
        begin
            addr_cand = {1'b0, poll_addr_reg} + (ADDR_W+1)'(1);
        end
        addr_wrap      = addr_cand >= (ADDR_W+1)'(NUM_CABS);
        addr_poll_next = addr_wrap ? '0 : addr_cand[ADDR_W-1:0];
    end

    assign rd_addr = (cmd == cpm_pkg::CMD_POLL) ? addr_poll_next : cab_index[ADDR_W-1:0];

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpm_pkg::ST_IDLE;
            poll_addr_reg <= '0;
            round_reg     <= 32'd0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= exec;
            if (accept && cmd == cpm_pkg::CMD_POLL)
            begin
                poll_addr_reg <= addr_poll_next;
                if (addr_wrap)
                begin
                    round_reg <= round_reg + 32'd1;
                end
            end
        end
    end

    // Item capture at acceptance and result capture at the end of execution.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg             <= rd_addr;
            item_reg.cmd         <= cmd;
            item_reg.reply_count <= reply_count;
            item_reg.key_code    <= key_code;
            item_reg.speed_value <= speed_value;
            item_reg.dirty_mask  <= dirty_mask;
            item_reg.in_range    <= {1'b0, cab_index} < 7'(NUM_CABS);
            if (cmd == cpm_pkg::CMD_POLL)
            begin
                ping_reg <= cpm_pkg::PING_BASE | 8'(addr_poll_next);
            end
            else
            begin
                ping_reg <= cpm_pkg::PING_BASE;
            end
        end
        if (exec)
        begin
            result_reg <= result;
        end
    end

    cpm_cab_mem #(
        .NUM_CABS (NUM_CABS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (entry_rd),
        .wr_en   (exec && wr_en),
        .wr_addr (addr_reg),
        .wr_data (entry_wr)
    );

    cpm_update u_update (
        .item        (item_reg),
        .entry       (entry_rd),
        .round_count (round_reg),
        .entry_new   (entry_wr),
        .wr_en       (wr_en),
        .result      (result)
    );

    // Result beat: held for the single cycle that done is high.
    assign done          = done_reg;
    assign ping_byte     = ping_reg;
    assign cab_present   = result_reg.present;
    assign command_code  = result_reg.code;
    assign command_value = result_reg.value;
    assign screen_sent   = result_reg.sent;
    assign screen_header = result_reg.header;

endmodule

>>> rtl/cpm_cab_mem.sv
// Per-cab state memory with one read and one write port, read data registered.
// Valid bits stand in for the reset contents; depends on cpm_pkg.
module cpm_cab_mem #(
    parameter int NUM_CABS = cpm_pkg::NUM_CABS_DEF,
    localparam int ADDR_W = $clog2(NUM_CABS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output cpm_pkg::cab_entry_t rd_data,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  cpm_pkg::cab_entry_t wr_data
);

    cpm_pkg::cab_entry_t mem [NUM_CABS];
    cpm_pkg::cab_entry_t rd_data_reg;
    logic [NUM_CABS-1:0] valid_reg;
    logic                rd_valid_reg;

    // Storage array: synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // One valid bit per entry; an entry never written reads as its reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : cpm_pkg::ENTRY_RESET;

endmodule

>>> rtl/cpm_update.sv
// Modify step of the read-modify-write: decodes one item against its cab entry.
// Produces the entry to write back and the result fields; depends on cpm_pkg.
module cpm_update (
    input  cpm_pkg::item_t      item,
    input  cpm_pkg::cab_entry_t entry,
    input  logic [31:0]         round_count,
    output cpm_pkg::cab_entry_t entry_new,
    output logic                wr_en,
    output cpm_pkg::result_t    result
);

    logic [31:0] age;
    logic [3:0]  dirty;

    assign age = round_count - entry.last_seen;

    always_comb
    begin
        entry_new = entry;
        wr_en     = 1'b0;
        dirty     = entry.dirty;
        result    = '{present: 1'b0, code: cpm_pkg::CC_NONE, value: 8'd0,
                      sent: 1'b0, header: cpm_pkg::HDR_TL};

        case (item.cmd)
            cpm_pkg::CMD_POLL:
            begin
                wr_en = 1'b1;
                // A cab unseen for more than one round gets all screens redrawn.
                if (age > 32'd1)
                begin
                    dirty = cpm_pkg::SCR_ALL;
                end
                // Full reply: decode the key and update the flags.
                if (item.reply_count[1])
                begin
                    result.present  = 1'b1;
                    entry_new.last_seen = round_count;
                    case (item.key_code)
                        cpm_pkg::KEY_REPEAT:
                        begin
                            dirty               = cpm_pkg::SCR_ALL;
                            entry_new.question  = 1'b0;
                            entry_new.selecting = 1'b0;
                        end
                        cpm_pkg::KEY_SELECT:
                        begin
                            dirty               = dirty | cpm_pkg::SCR_BOTTOM;
                            entry_new.selecting = 1'b1;
                        end
                        cpm_pkg::KEY_ENTER:
                        begin
                            dirty = dirty | cpm_pkg::SCR_BOTTOM;
                            if (entry.selecting)
                            begin
                                result.code         = cpm_pkg::CC_SELECT;
                                entry_new.selecting = 1'b0;
                            end
                        end
                        cpm_pkg::KEY_ANSWER_0, cpm_pkg::KEY_ANSWER_1:
                        begin
                            if (entry.question)
                            begin
                                dirty              = dirty | cpm_pkg::SCR_BOTTOM;
                                result.code        = cpm_pkg::CC_RESPONSE;
                                result.value       = {7'd0,
                                    item.key_code == cpm_pkg::KEY_ANSWER_1};
                                entry_new.question = 1'b0;
                            end
                        end
                        cpm_pkg::KEY_SPEED_UP:
                        begin
                            result.code  = cpm_pkg::CC_SPEED;
                            result.value = entry.speed + 8'd1;
                        end
                        cpm_pkg::KEY_SPEED_DN:
                        begin
                            result.code  = cpm_pkg::CC_SPEED;
                            result.value = entry.speed - 8'd1;
                        end
                        default:
                        begin
                            // No key, or a key without meaning here.
                        end
                    endcase
                    // Send the first dirty screen in the order TL, BL, TR, BR.
                    if (dirty[3])
                    begin
                        result.sent   = 1'b1;
                        result.header = cpm_pkg::HDR_TL;
                        dirty[3]      = 1'b0;
                    end
                    else if (dirty[2])
                    begin
                        result.sent   = 1'b1;
                        result.header = cpm_pkg::HDR_BL;
                        dirty[2]      = 1'b0;
                    end
                    else if (dirty[1])
                    begin
                        result.sent   = 1'b1;
                        result.header = cpm_pkg::HDR_TR;
                        dirty[1]      = 1'b0;
                    end
                    else if (dirty[0])
                    begin
                        result.sent   = 1'b1;
                        result.header = cpm_pkg::HDR_BR;
                        dirty[0]      = 1'b0;
                    end
                end
            end
            cpm_pkg::CMD_SET_SPEED:
            begin
                wr_en           = item.in_range;
                entry_new.speed = item.speed_value;
                dirty           = dirty | cpm_pkg::SCR_BL;
            end
            cpm_pkg::CMD_QUESTION:
            begin
                wr_en              = item.in_range;
                entry_new.question = 1'b1;
                dirty              = dirty | cpm_pkg::SCR_BOTTOM;
            end
            default:
            begin
                wr_en = item.in_range;
                dirty = dirty | item.dirty_mask;
            end
        endcase

        entry_new.dirty = dirty;
    end

endmodule

>>> test/cab_poll_master_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for cab_poll_master: directed and random command beats,
// each result checked against a local prediction of the poll master's state.
// Depends on cpm_pkg and the cab_poll_master RTL.
module cab_poll_master_test;
    import cpm_pkg::*;

    localparam int NCABS       = NUM_CABS_DEF;
    localparam int ITEMS_TOTAL = 1050;

    // One command beat as presented on the input ports.
    typedef struct {
        logic [1:0] cmd;
        logic [1:0] reply_count;
        logic [7:0] key_code;
        logic [5:0] cab_index;
        logic [7:0] speed_value;
        logic [3:0] dirty_mask;
    } cab_beat_t;

    // One result beat as expected on the output ports.
    typedef struct {
        logic [7:0] ping;
        logic       present;
        logic [1:0] code;
        logic [7:0] value;
        logic       sent;
        logic [7:0] header;
    } reply_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] cmd = '0;
    logic [1:0] reply_count = '0;
    logic [7:0] key_code = '0;
    logic [5:0] cab_index = '0;
    logic [7:0] speed_value = '0;
    logic [3:0] dirty_mask = '0;
    logic       done;
    logic [7:0] ping_byte;
    logic       cab_present;
    logic [1:0] command_code;
    logic [7:0] command_value;
    logic       screen_sent;
    logic [7:0] screen_header;

    cab_beat_t   pending_items[$];
    reply_beat_t expected_replies[$];
    cab_beat_t   beat_on_bus;
    int          gap_left = 0;
    int          calm_left = 0;
    int          error_count = 0;
    int          items_made = 0;
    logic [5:0]  gen_addr = '0;

    // Shadow copy of the poll master's state.
    logic [5:0]  shadow_addr;
    logic [31:0] shadow_round;
    logic [7:0]  shadow_speed [NCABS];
    logic [3:0]  shadow_dirty [NCABS];
    logic        shadow_question [NCABS];
    logic        shadow_selecting [NCABS];
    logic [31:0] shadow_seen [NCABS];
    logic [1:0]  shadow_code [NCABS];
    logic [7:0]  shadow_value [NCABS];

    cab_poll_master #(.NUM_CABS(NCABS)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .reply_count   (reply_count),
        .key_code      (key_code),
        .cab_index     (cab_index),
        .speed_value   (speed_value),
        .dirty_mask    (dirty_mask),
        .done          (done),
        .ping_byte     (ping_byte),
        .cab_present   (cab_present),
        .command_code  (command_code),
        .command_value (command_value),
        .screen_sent   (screen_sent),
        .screen_header (screen_header)
    );

    always #2 clk = ~clk;

    // Address polled after a; addresses 1 and 2 are never polled.
    function automatic logic [5:0] next_poll_addr(input logic [5:0] a);
        int n;
        n = int'(a) + 1;
        if (n == 1)
            n = 2;
        if (n == 2)
            n = 3;
        if (n >= NCABS)
            n = 0;
        return n[5:0];
    endfunction

    // Applies one accepted beat to the shadow state and returns the reply it causes.
    function automatic reply_beat_t predict_reply(input cab_beat_t b);
        reply_beat_t r;
        logic [5:0]  a;
        logic [31:0] unseen;
        r.ping    = PING_BASE;
        r.present = 1'b0;
        r.code    = CC_NONE;
        r.value   = 8'h00;
        r.sent    = 1'b0;
        r.header  = HDR_TL;
        if (b.cmd == CMD_POLL)
        begin
            a = next_poll_addr(shadow_addr);
            if (a == 6'd0)
                shadow_round = shadow_round + 32'd1;
            shadow_addr = a;
            r.ping = PING_BASE | {2'b00, a};
            // A cab missing for more than a round gets all its screens redrawn.
            unseen = shadow_round - shadow_seen[a];
            if (unseen > 32'd1)
                shadow_dirty[a] = SCR_ALL;
            if (b.reply_count == 2'd1)
            begin
                shadow_code[a]  = CC_NONE;
                shadow_value[a] = 8'h00;
            end
            else if (b.reply_count >= 2'd2)
            begin
                r.present       = 1'b1;
                shadow_code[a]  = CC_NONE;
                shadow_value[a] = 8'h00;
                shadow_seen[a]  = shadow_round;
                case (b.key_code)
                    KEY_REPEAT:
                    begin
                        shadow_dirty[a]     = SCR_ALL;
                        shadow_question[a]  = 1'b0;
                        shadow_selecting[a] = 1'b0;
                    end
                    KEY_SELECT:
                    begin
                        shadow_dirty[a]     = shadow_dirty[a] | SCR_BOTTOM;
                        shadow_selecting[a] = 1'b1;
                    end
                    KEY_ENTER:
                    begin
                        shadow_dirty[a] = shadow_dirty[a] | SCR_BOTTOM;
                        if (shadow_selecting[a])
                        begin
                            shadow_code[a]      = CC_SELECT;
                            shadow_selecting[a] = 1'b0;
                        end
                    end
                    KEY_ANSWER_0, KEY_ANSWER_1:
                    begin
                        if (shadow_question[a])
                        begin
                            shadow_dirty[a]    = shadow_dirty[a] | SCR_BOTTOM;
                            shadow_code[a]     = CC_RESPONSE;
                            shadow_value[a]    = (b.key_code == KEY_ANSWER_1) ? 8'h01 : 8'h00;
                            shadow_question[a] = 1'b0;
                        end
                    end
                    KEY_SPEED_UP:
                    begin
                        shadow_code[a]  = CC_SPEED;
                        shadow_value[a] = shadow_speed[a] + 8'd1;
                    end
                    KEY_SPEED_DN:
                    begin
                        shadow_code[a]  = CC_SPEED;
                        shadow_value[a] = shadow_speed[a] - 8'd1;
                    end
                    default:
                    begin
                    end
                endcase
                r.code  = shadow_code[a];
                r.value = shadow_value[a];
                // First dirty screen goes out, in the order TL, BL, TR, BR.
                if (shadow_dirty[a] != 4'h0)
                begin
                    r.sent = 1'b1;
                    if (shadow_dirty[a][3])
                    begin
                        shadow_dirty[a][3] = 1'b0;
                        r.header = HDR_TL;
                    end
                    else if (shadow_dirty[a][2])
                    begin
                        shadow_dirty[a][2] = 1'b0;
                        r.header = HDR_BL;
                    end
                    else if (shadow_dirty[a][1])
                    begin
                        shadow_dirty[a][1] = 1'b0;
                        r.header = HDR_TR;
                    end
                    else
                    begin
                        shadow_dirty[a][0] = 1'b0;
                        r.header = HDR_BR;
                    end
                end
            end
        end
        else if (int'(b.cab_index) < NCABS)
        begin
            if (b.cmd == CMD_SET_SPEED)
            begin
                shadow_speed[b.cab_index] = b.speed_value;
                shadow_dirty[b.cab_index] = shadow_dirty[b.cab_index] | SCR_BL;
            end
            else if (b.cmd == CMD_QUESTION)
            begin
                shadow_question[b.cab_index] = 1'b1;
                shadow_dirty[b.cab_index]    = shadow_dirty[b.cab_index] | SCR_BOTTOM;
            end
            else
            begin
                shadow_dirty[b.cab_index] = shadow_dirty[b.cab_index] | b.dirty_mask;
            end
        end
        return r;
    endfunction

    // Idle time after a beat: mostly none or short, a few long, and calm stretches.
    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left = calm_left - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Appends a beat to the pending list, tracking the address the next poll reaches.
    task automatic queue_item(input logic [1:0] c, input logic [1:0] rc, input logic [7:0] k,
                              input logic [5:0] ci, input logic [7:0] sv, input logic [3:0] dm);
        cab_beat_t b;
        b.cmd         = c;
        b.reply_count = rc;
        b.key_code    = k;
        b.cab_index   = ci;
        b.speed_value = sv;
        b.dirty_mask  = dm;
        if (c == CMD_POLL)
            gen_addr = next_poll_addr(gen_addr);
        pending_items.push_back(b);
        items_made = items_made + 1;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
            error_count = error_count + 1;
        end
    endtask

    // Driver: presents pending beats, with random idle time between them.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                expected_replies.push_back(predict_reply(beat_on_bus));
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    beat_on_bus = pending_items.pop_front();
                    cmd         <= beat_on_bus.cmd;
                    reply_count <= beat_on_bus.reply_count;
                    key_code    <= beat_on_bus.key_code;
                    cab_index   <= beat_on_bus.cab_index;
                    speed_value <= beat_on_bus.speed_value;
                    dirty_mask  <= beat_on_bus.dirty_mask;
                    start       <= 1'b1;
                    gap_left    <= pick_gap();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: each result beat is compared with the oldest expected reply.
    always @(posedge clk)
    begin : result_monitor
        reply_beat_t want;
        if (rst_n && done)
        begin
            if (expected_replies.size() == 0)
            begin
                $display("%0t: result beat with none expected, expected nothing, actual ping %02h",
                         $time, ping_byte);
                error_count = error_count + 1;
            end
            else
            begin
                want = expected_replies.pop_front();
                check_field("ping_byte", want.ping, ping_byte);
                check_field("cab_present", {7'd0, want.present}, {7'd0, cab_present});
                check_field("command_code", {6'd0, want.code}, {6'd0, command_code});
                check_field("command_value", want.value, command_value);
                check_field("screen_sent", {7'd0, want.sent}, {7'd0, screen_sent});
                check_field("screen_header", want.header, screen_header);
            end
        end
    end

    // Stimulus, reset and the end of the run.
    initial
    begin
        int r;
        int sel;
        logic [7:0] k;
        logic [1:0] rc;
        logic answer_due;

        shadow_addr  = '0;
        shadow_round = '0;
        for (int i = 0; i < NCABS; i++)
        begin
            shadow_speed[i]     = SPEED_RESET;
            shadow_dirty[i]     = SCR_ALL;
            shadow_question[i]  = 1'b0;
            shadow_selecting[i] = 1'b0;
            shadow_seen[i]      = '0;
            shadow_code[i]      = CC_NONE;
            shadow_value[i]     = 8'h00;
        end

        // Directed beats: speed wrap both ways, answers with and without a question,
        // enter without select, timeout, no reply, reply count of three, odd keys.
        queue_item(CMD_SET_SPEED, 2'd0, 8'h00, 6'd3, 8'hFF, 4'h0);
        queue_item(CMD_POLL, 2'd2, KEY_SPEED_UP, 6'd0, 8'h00, 4'h0);
        queue_item(CMD_SET_SPEED, 2'd3, 8'hFF, 6'd4, 8'h00, 4'hF);
        queue_item(CMD_POLL, 2'd2, KEY_SPEED_DN, 6'd63, 8'hFF, 4'hF);
        queue_item(CMD_QUESTION, 2'd0, 8'h00, 6'd5, 8'h00, 4'h0);
        queue_item(CMD_POLL, 2'd2, KEY_ANSWER_1, 6'd0, 8'h00, 4'h0);
        queue_item(CMD_QUESTION, 2'd1, 8'h55, 6'd6, 8'hAA, 4'h5);
        queue_item(CMD_POLL, 2'd3, KEY_ANSWER_0, 6'd0, 8'h00, 4'h0);
        queue_item(CMD_POLL, 2'd2, KEY_ANSWER_0, 6'd0, 8'h00, 4'h0);
        queue_item(CMD_POLL, 2'd2, KEY_SELECT, 6'd0, 8'h00, 4'h0);
        queue_item(CMD_POLL, 2'd2, KEY_ENTER, 6'd0, 8'h00, 4'h0);
        queue_item(CMD_POLL, 2'd1, KEY_SPEED_UP, 6'd0, 8'h00, 4'h0);
        queue_item(CMD_POLL, 2'd0, KEY_REPEAT, 6'd0, 8'h00, 4'h0);
        queue_item(CMD_POLL, 2'd2, KEY_REPEAT, 6'd0, 8'h00, 4'h0);
        queue_item(CMD_POLL, 2'd2, 8'hFF, 6'd0, 8'h00, 4'h0);
        queue_item(CMD_POLL, 2'd2, 8'h00, 6'd0, 8'h00, 4'h0);
        queue_item(CMD_MARK, 2'd0, 8'h00, 6'd63, 8'h00, 4'hF);
        queue_item(CMD_MARK, 2'd2, 8'hFF, 6'd0, 8'hFF, 4'h0);
        queue_item(CMD_QUESTION, 2'd0, 8'h00, 6'd0, 8'h00, 4'h0);
        queue_item(CMD_SET_SPEED, 2'd0, 8'h00, 6'd63, 8'h80, 4'h0);
        queue_item(CMD_POLL, 2'd2, KEY_NONE, 6'd0, 8'h00, 4'h0);

        // Random beats: mostly full replies with meaningful keys, host updates aimed
        // at the cab polled next, and some fully random noise.
        answer_due = 1'b0;
        while (items_made < ITEMS_TOTAL)
        begin
            r = $urandom_range(0, 99);
            sel = $urandom_range(0, 19);
            rc = (sel < 3) ? 2'd0 : (sel < 5) ? 2'd1 : (sel < 18) ? 2'd2 : 2'd3;
            case ($urandom_range(0, 9))
                0: k = KEY_REPEAT;
                1: k = KEY_SELECT;
                2: k = KEY_ENTER;
                3: k = KEY_ANSWER_0;
                4: k = KEY_ANSWER_1;
                5: k = KEY_SPEED_UP;
                6: k = KEY_SPEED_DN;
                7: k = KEY_NONE;
                default: k = 8'($urandom_range(0, 255));
            endcase
            if (answer_due)
            begin
                if ($urandom_range(0, 9) < 7)
                    k = $urandom_range(0, 1) ? KEY_ANSWER_1 : KEY_ANSWER_0;
                queue_item(CMD_POLL, 2'd2, k, 6'($urandom_range(0, 63)),
                           8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
                answer_due = 1'b0;
            end
            else if (r < 55)
            begin
                queue_item(CMD_POLL, rc, k, 6'($urandom_range(0, 63)),
                           8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
            end
            else if (r < 63)
            begin
                queue_item(CMD_QUESTION, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                           next_poll_addr(gen_addr), 8'($urandom_range(0, 255)),
                           4'($urandom_range(0, 15)));
                answer_due = 1'b1;
            end
            else if (r < 72)
            begin
                queue_item(CMD_SET_SPEED, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                           (r < 67) ? next_poll_addr(gen_addr) : 6'($urandom_range(0, 63)),
                           8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
            end
            else if (r < 82)
            begin
                queue_item(CMD_MARK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                           6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                           4'($urandom_range(0, 15)));
            end
            else
            begin
                queue_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                           8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                           8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every beat to go in and every reply to come back.
        @(posedge clk);
        while (pending_items.size() != 0 || start || expected_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Overall limit on the run.
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
